FILE: rtl/core/cgr_pkg.sv
// cgr_pkg: shared types and constants for the color gradient ramp
// no dependencies
package cgr_pkg;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_EVAL   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RSVD      = 2'd3
  } status_e;

  localparam int unsigned PosW    = 17;
  localparam int unsigned ChW     = 16;
  localparam int unsigned ColorW  = 4 * ChW;
  localparam int unsigned CountW  = 5;
  localparam int unsigned InDataW = 112;  // 2+17+64 = 83 bits, padded to 14 bytes
  localparam int unsigned OutDataW = 72;  // 2+64+5 = 71 bits, padded to 9 bytes
  localparam logic signed [PosW-1:0] OnePos = 17'sd32768;
  localparam logic [ChW-1:0] ChMax = 16'hFFFF;

endpackage

FILE: rtl/core/color_gradient_ramp_top.sv
// color_gradient_ramp_top: sorted gradient mark table with evaluate, in
// position and color memories. depends on cgr_pkg
//
// usage
//   s_axis: one command word per handshake; tdata from bit 0 up holds
//     cmd[1:0], position[16:0] (signed q2.15), red, green, blue, alpha
//   m_axis: one result word per command; tdata from bit 0 up holds
//     status[1:0], red, green, blue, alpha, mark_count[4:0]
//   the mark table lives in two one-port-read memories (position, color)
//   with a registered read; a sequencer walks them one entry per
//   step: search takes a read and a check state per entry scanned,
//   insert/remove shift moves one entry per read and write state pair,
//   and evaluate ends in a restoring divider that settles one quotient
//   bit per cycle (48 bits) for each of three channels, plus a
//   multiply step per channel
//   one command is worked on at a time; s_axis_tready is low while busy
//   and rises as the result word is loaded into the output register
//   reset clears the mark count, state and output valid; entries are written before read
//   if the receiver stalls the result stays in the output register and
//   the next command is still taken and run; its result waits in a
//   staging register until the output register frees
module color_gradient_ramp_top #(
  parameter int unsigned MAX_MARKS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [cgr_pkg::InDataW-1:0]   s_axis_tdata,   // cmd, position, r, g, b, a
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [cgr_pkg::OutDataW-1:0]  m_axis_tdata    // status, r, g, b, a, count
);
  import cgr_pkg::*;

  localparam int unsigned IdxW = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_MARKS + 1);
  localparam int unsigned DivW = 48;  // numerator width covers 16b x 18b + rounding

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_DISPATCH, S_SHUP_RD, S_SHUP_WR,
    S_SHDN_RD, S_SHDN_WR, S_RDCOL, S_EV_LO, S_EV_HI, S_MUL, S_DIV,
    S_DONE
  } state_e;

  // memories
  logic signed [PosW-1:0] pos_mem [MAX_MARKS];
  logic [ColorW-1:0]      col_mem [MAX_MARKS];
  logic [IdxW-1:0]        rd_addr, wr_addr;
  logic                   wr_en;
  logic signed [PosW-1:0] wr_pos;
  logic [ColorW-1:0]      wr_col;
  logic signed [PosW-1:0] rd_pos_q;
  logic [ColorW-1:0]      rd_col_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pos_mem[wr_addr] <= wr_pos;
      col_mem[wr_addr] <= wr_col;
    end
    rd_pos_q <= pos_mem[rd_addr];
    rd_col_q <= col_mem[rd_addr];
  end

  state_e                 state_q, state_d;
  logic [CntW-1:0]        held_q, held_d;
  logic [CntW-1:0]        idx_q, idx_d;     // scan index
  cmd_e                   cmd_q, cmd_d;
  logic signed [PosW-1:0] pos_q, pos_d;
  logic [ColorW-1:0]      col_q, col_d;     // command color / upper mark color on evaluate
  logic                   found_q, found_d;
  logic [CntW-1:0]        fidx_q, fidx_d;   // match index or first > query
  logic signed [PosW-1:0] lpos_q, lpos_d;
  logic [ColorW-1:0]      lcol_q, lcol_d;
  logic [17:0]            dist_q, dist_d, toff_q, toff_d;
  logic [1:0]             ch_q, ch_d;
  logic [DivW-1:0]        num_q, num_d, rem_q, rem_d;
  logic [5:0]             bit_q, bit_d;
  logic [ChW-1:0]         res_q [3];
  logic [ChW-1:0]         res_d [3];
  logic                   ovld_q, ovld_d;
  logic [OutDataW-1:0]    odat_q, odat_d;
  logic [OutDataW-1:0]    word_q, word_d;   // finished word waiting for the output register

  logic signed [PosW-1:0] in_pos, qpos;
  assign in_pos = s_axis_tdata[18:2];
  assign qpos = (pos_q < 0) ? '0 : ((pos_q > OnePos) ? OnePos : pos_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odat_q;

  function automatic logic [ChW-1:0] chsel(logic [ColorW-1:0] c, logic [1:0] k);
    return c[k*ChW +: ChW];
  endfunction

  // one divider step: shift in numerator msb, trial subtract
  logic [DivW:0] trial;
  assign trial = {rem_q, num_q[DivW-1]} - {{(DivW-17){1'b0}}, dist_q};

  always_comb begin
    state_d = state_q; held_d = held_q; idx_d = idx_q; cmd_d = cmd_q;
    pos_d = pos_q; col_d = col_q; found_d = found_q; fidx_d = fidx_q;
    lpos_d = lpos_q; lcol_d = lcol_q; dist_d = dist_q; toff_d = toff_q;
    ch_d = ch_q; num_d = num_q; rem_d = rem_q; bit_d = bit_q;
    res_d = res_q; ovld_d = ovld_q; odat_d = odat_q; word_d = word_q;
    rd_addr = idx_q[IdxW-1:0]; wr_addr = idx_q[IdxW-1:0]; wr_en = 1'b0;
    wr_pos = pos_q; wr_col = col_q;
    if (ovld_q && m_axis_tready) ovld_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d = cmd_e'(s_axis_tdata[1:0]);
          pos_d = in_pos;
          col_d = s_axis_tdata[82:19];
          idx_d = '0; found_d = 1'b0; fidx_d = held_q;
          res_d[0] = '0; res_d[1] = '0; res_d[2] = '0;
          state_d = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        // scan for exact match (add/remove/read) or first mark above query
        if (idx_q == held_q) state_d = S_DISPATCH;
        else state_d = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (cmd_q == CMD_EVAL) begin
          if (rd_pos_q > qpos) begin
            fidx_d = idx_q; state_d = S_DISPATCH;
          end else begin
            lpos_d = rd_pos_q; lcol_d = rd_col_q;
            idx_d = idx_q + 1'b1; state_d = S_SRCH_RD;
          end
        end else if (rd_pos_q == pos_q) begin
          found_d = 1'b1; fidx_d = idx_q; lcol_d = rd_col_q; state_d = S_DISPATCH;
        end else begin
          if (rd_pos_q > pos_q && fidx_q == held_q) fidx_d = idx_q;
          idx_d = idx_q + 1'b1; state_d = S_SRCH_RD;
        end
      end
      S_DISPATCH: begin
        case (cmd_q)
          CMD_ADD: begin
            if (found_q) begin
              wr_addr = fidx_q[IdxW-1:0]; wr_en = 1'b1;
              word_d = {1'b0, 5'(held_q), 64'd0, ST_OK};
              state_d = S_DONE;
            end else if (held_q >= CntW'(MAX_MARKS)) begin
              word_d = {1'b0, 5'(held_q), 64'd0, ST_FULL};
              state_d = S_DONE;
            end else begin
              idx_d = held_q; state_d = S_SHUP_RD;
            end
          end
          CMD_REMOVE: begin
            if (!found_q) begin
              word_d = {1'b0, 5'(held_q), 64'd0, ST_NOT_FOUND};
              state_d = S_DONE;
            end else begin
              idx_d = fidx_q; state_d = S_SHDN_RD;
            end
          end
          CMD_READ: begin
            word_d = {1'b0, 5'(held_q), found_q ? lcol_q : 64'd0,
                      found_q ? ST_OK : ST_NOT_FOUND};
            state_d = S_DONE;
          end
          default: begin
            if (held_q == '0) begin
              word_d = {1'b0, 5'(held_q), {4{ChMax}}, ST_OK};
              state_d = S_DONE;
            end else if (fidx_q == '0) begin
              idx_d = '0; state_d = S_RDCOL;
            end else if (fidx_q == held_q) begin
              word_d = {1'b0, 5'(held_q), lcol_q, ST_OK};
              state_d = S_DONE;
            end else begin
              idx_d = fidx_q; state_d = S_EV_LO;
            end
          end
        endcase
      end
      S_SHUP_RD: begin
        // idx_q is hole; move idx-1 up while above new position
        rd_addr = IdxW'(idx_q - 1'b1);
        if (idx_q == fidx_q || idx_q == '0) begin
          wr_pos = pos_q; wr_col = col_q; wr_en = 1'b1;
          held_d = held_q + 1'b1;
          word_d = {1'b0, 5'(held_q + 1'b1), 64'd0, ST_OK};
          state_d = S_DONE;
        end else state_d = S_SHUP_WR;
      end
      S_SHUP_WR: begin
        wr_pos = rd_pos_q; wr_col = rd_col_q; wr_en = 1'b1;
        idx_d = idx_q - 1'b1; state_d = S_SHUP_RD;
      end
      S_SHDN_RD: begin
        rd_addr = IdxW'(idx_q + 1'b1);
        if (idx_q + 1'b1 >= held_q) begin
          held_d = held_q - 1'b1;
          word_d = {1'b0, 5'(held_q - 1'b1), 64'd0, ST_OK};
          state_d = S_DONE;
        end else state_d = S_SHDN_WR;
      end
      S_SHDN_WR: begin
        wr_pos = rd_pos_q; wr_col = rd_col_q; wr_en = 1'b1;
        idx_d = idx_q + 1'b1; state_d = S_SHDN_RD;
      end
      S_RDCOL: state_d = S_EV_HI;  // read issued at idx 0
      S_EV_LO: state_d = S_EV_HI;  // upper mark read in flight
      S_EV_HI: begin
        if (fidx_q == '0) begin
          word_d = {1'b0, 5'(held_q), rd_col_q, ST_OK};
          state_d = S_DONE;
        end else begin
          col_d = rd_col_q;
          dist_d = 18'(rd_pos_q - lpos_q);
          toff_d = 18'(qpos - lpos_q);
          ch_d = '0; state_d = S_MUL;
        end
      end
      S_MUL: begin
        num_d = DivW'(chsel(lcol_q, ch_q) * (dist_q - toff_q))
              + DivW'(chsel(col_q, ch_q) * toff_q) + DivW'(dist_q >> 1);
        rem_d = '0; bit_d = 6'(DivW); state_d = S_DIV;
      end
      S_DIV: begin
        if (!trial[DivW]) rem_d = trial[DivW-1:0];
        else rem_d = {rem_q[DivW-2:0], num_q[DivW-1]};
        num_d = {num_q[DivW-2:0], ~trial[DivW]};
        bit_d = bit_q - 1'b1;
        if (bit_q == 6'd1) begin
          res_d[ch_q] = num_d[ChW-1:0];
          if (ch_q == 2'd2) begin
            word_d = {1'b0, 5'(held_q), ChMax, res_d[2], res_d[1], res_d[0], ST_OK};
            state_d = S_DONE;
          end else begin
            ch_d = ch_q + 1'b1; state_d = S_MUL;
          end
        end
      end
      S_DONE: begin
        // hand the word over once the output register is free
        if (!ovld_q || m_axis_tready) begin
          odat_d = word_q; ovld_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; held_q <= '0; ovld_q <= 1'b0;
    end else begin
      state_q <= state_d; held_q <= held_d; ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; cmd_q <= cmd_d; pos_q <= pos_d; col_q <= col_d;
    found_q <= found_d; fidx_q <= fidx_d; lpos_q <= lpos_d; lcol_q <= lcol_d;
    dist_q <= dist_d; toff_q <= toff_d; ch_q <= ch_d; num_q <= num_d;
    rem_q <= rem_d; bit_q <= bit_d; res_q <= res_d; odat_q <= odat_d;
    word_q <= word_d;
  end

endmodule

FILE: rtl/core/cgr_checker.sv
// cgr_checker: port-level checks for color_gradient_ramp_top, and bind
// depends on cgr_pkg
module cgr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [cgr_pkg::OutDataW-1:0]  m_axis_tdata
);
  import cgr_pkg::*;

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != ST_RSVD) else $error("bad status");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("took two");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[70:66] <= 5'd16) else $error("count range");

endmodule

bind color_gradient_ramp_top cgr_checker u_cgr_checker (.*);

FILE: tb/tb_color_gradient_ramp_top.sv
// tb_color_gradient_ramp_top: self-checking testbench for the gradient mark table
// depends on cgr_pkg and color_gradient_ramp_top; predicts every result word
// and compares it field by field with the block's output stream
module tb_color_gradient_ramp_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cgr_pkg::*;

  localparam int unsigned MaxMarks = 16;
  localparam int unsigned CycleLimit = 1500000;

  typedef struct packed {
    logic [ChW-1:0] alpha;
    logic [ChW-1:0] blue;
    logic [ChW-1:0] green;
    logic [ChW-1:0] red;
  } color_t;

  typedef struct {
    status_e        status;
    color_t         color;
    logic [CountW-1:0] count;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // prediction state: sorted mark table
  logic signed [PosW-1:0] grad_pos[MaxMarks];
  color_t grad_color[MaxMarks];
  int unsigned grad_held;
  result_t pending_results[$];

  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit calm = 1'b0;  // no idling while set

  color_gradient_ramp_top #(.MAX_MARKS(MaxMarks)) uut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL color_gradient_ramp_top");
      $finish;
    end
  end

  function automatic int find_mark(logic signed [PosW-1:0] p);
    for (int i = 0; i < int'(grad_held); i++) begin
      if (grad_pos[i] == p) return i;
    end
    return -1;
  endfunction

  // model one command and return its result word
  function automatic result_t predict_gradient(cmd_e cmd, logic signed [PosW-1:0] p,
                                               color_t c);
    result_t r;
    int idx;
    int i;
    int up;
    longint q, d, t, num;
    logic [ChW-1:0] lo, hi;
    r.status = ST_OK;
    r.color = '0;
    idx = find_mark(p);
    case (cmd)
      CMD_ADD: begin
        if (idx >= 0) begin
          grad_color[idx] = c;
        end else if (grad_held >= MaxMarks) begin
          r.status = ST_FULL;
        end else begin
          i = int'(grad_held);
          while (i > 0 && grad_pos[i-1] > p) begin
            grad_pos[i] = grad_pos[i-1];
            grad_color[i] = grad_color[i-1];
            i--;
          end
          grad_pos[i] = p;
          grad_color[i] = c;
          grad_held++;
        end
      end
      CMD_REMOVE: begin
        if (idx < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (i = idx; i + 1 < int'(grad_held); i++) begin
            grad_pos[i] = grad_pos[i+1];
            grad_color[i] = grad_color[i+1];
          end
          grad_held--;
        end
      end
      CMD_READ: begin
        if (idx < 0) r.status = ST_NOT_FOUND;
        else r.color = grad_color[idx];
      end
      default: begin
        if (grad_held == 0) begin
          r.color = {4{ChMax}};
        end else begin
          q = p < 0 ? 0 : (p > 32768 ? 32768 : longint'(p));
          up = 0;
          while (up < int'(grad_held) && longint'(grad_pos[up]) <= q) up++;
          if (up == 0) begin
            r.color = grad_color[0];
          end else if (up == int'(grad_held)) begin
            r.color = grad_color[grad_held-1];
          end else begin
            d = longint'(grad_pos[up]) - longint'(grad_pos[up-1]);
            t = q - longint'(grad_pos[up-1]);
            for (int k = 0; k < 3; k++) begin
              lo = grad_color[up-1][k*ChW +: ChW];
              hi = grad_color[up][k*ChW +: ChW];
              num = longint'(lo) * (d - t) + longint'(hi) * t + d / 2;
              r.color[k*ChW +: ChW] = ChW'(num / d);
            end
            r.color.alpha = ChMax;
          end
        end
      end
    endcase
    r.count = CountW'(grad_held);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  // send one command word, predicting its result at acceptance
  task automatic send_command(cmd_e cmd, logic signed [PosW-1:0] p, color_t c);
    while (!calm && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {29'b0, c, p, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_gradient(cmd, p, c));
  endtask

  // receiver: random stalls, compare against the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", longint'(m_axis_tdata[63:0]), 0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[1:0] != want.status)
          report_mismatch("status", longint'(m_axis_tdata[1:0]), longint'(want.status));
        if (m_axis_tdata[17:2] != want.color.red)
          report_mismatch("red", longint'(m_axis_tdata[17:2]), longint'(want.color.red));
        if (m_axis_tdata[33:18] != want.color.green)
          report_mismatch("green", longint'(m_axis_tdata[33:18]),
                          longint'(want.color.green));
        if (m_axis_tdata[49:34] != want.color.blue)
          report_mismatch("blue", longint'(m_axis_tdata[49:34]), longint'(want.color.blue));
        if (m_axis_tdata[65:50] != want.color.alpha)
          report_mismatch("alpha", longint'(m_axis_tdata[65:50]),
                          longint'(want.color.alpha));
        if (m_axis_tdata[70:66] != want.count)
          report_mismatch("count", longint'(m_axis_tdata[70:66]), longint'(want.count));
      end
    end
    m_axis_tready <= calm || ($urandom_range(99) >= 14);
  end

  function automatic color_t rand_color();
    return {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  function automatic logic signed [PosW-1:0] rand_in_range();
    return PosW'($urandom_range(32768));
  endfunction

  // drop valid and hold off until every expected word has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // extremes of fields, empty evaluate, full table, misses
  task automatic test_directed();
    send_command(CMD_EVAL, 17'sd100, '0);
    send_command(CMD_READ, 17'sd0, '0);
    send_command(CMD_REMOVE, 17'sd0, '0);
    send_command(CMD_ADD, 17'sd0, '0);
    send_command(CMD_ADD, 17'sd32768, {4{16'hFFFF}});
    send_command(CMD_EVAL, 17'sd16384, '0);
    send_command(CMD_EVAL, -17'sd65536, '0);
    send_command(CMD_EVAL, 17'sd65535, '0);
    send_command(CMD_ADD, 17'sd0, 64'h1234_ffff_0000_aaaa);
    send_command(CMD_READ, 17'sd0, '0);
    send_command(CMD_ADD, -17'sd65536, 64'h5555_0000_ffff_0001);
    send_command(CMD_ADD, 17'sd65535, 64'h0f0f_f0f0_0000_ffff);
    send_command(CMD_EVAL, 17'sd1, '0);
    send_command(CMD_READ, 17'sd65535, '0);
    for (int i = 0; i < 14; i++) send_command(CMD_ADD, 17'(100 + i * 2000), rand_color());
    send_command(CMD_EVAL, 17'sd3000, '0);
    send_command(CMD_REMOVE, 17'sd0, '0);
    wait_drained();
  endtask

  // random mix, half of the positions drawn from existing marks
  task automatic test_random(int unsigned n);
    cmd_e cmd;
    logic signed [PosW-1:0] p;
    for (int unsigned i = 0; i < n; i++) begin
      calm = (i >= n / 3 && i < n / 3 + 60);
      cmd = cmd_e'($urandom_range(3));
      if (grad_held > 0 && $urandom_range(99) < 50) p = grad_pos[$urandom_range(grad_held - 1)];
      else if ($urandom_range(99) < 75) p = rand_in_range();
      else p = PosW'($urandom);
      // bias toward adds while sparse, removes while full
      if (grad_held < 3 && $urandom_range(1)) cmd = CMD_ADD;
      if (grad_held == MaxMarks && $urandom_range(1)) cmd = CMD_REMOVE;
      send_command(cmd, p, rand_color());
      if (i == n / 2) wait_drained();  // sender hold-off
    end
    calm = 1'b0;
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < MaxMarks; i++) begin
      grad_pos[i] = '0;
      grad_color[i] = '0;
    end
    grad_held = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(530);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS color_gradient_ramp_top");
    end else begin
      $display("FAIL color_gradient_ramp_top");
    end
    $finish;
  end
endmodule
